[src/gated_multichannel_block_averager_defines.svh]
// assertion macros used by gmba_ctrl
`ifndef GATED_MULTICHANNEL_BLOCK_AVERAGER_DEFINES_SVH
`define GATED_MULTICHANNEL_BLOCK_AVERAGER_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define GMBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define GMBA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GMBA_ASSERT(lbl, prop, msg)
`define GMBA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[src/gmba_pkg.sv]
package gmba_pkg;

	localparam int NUM_CH         = 5;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;
	localparam int THRESH_BITS    = 12;
	localparam int CNT_CFG_BITS   = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_MODE          = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_USES_FWD = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD     = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AVERAGE_COUNT = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_WINDOW   = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_MAJORITY = 3'd5;

	localparam logic                    RST_MODE          = 1'b0;
	localparam logic                    RST_STOP_USES_FWD = 1'b1;
	localparam logic [THRESH_BITS-1:0]  RST_THRESHOLD     = 12'd10;
	localparam logic [CNT_CFG_BITS-1:0] RST_AVERAGE_COUNT = 16'd10000;
	localparam logic [CNT_CFG_BITS-1:0] RST_STOP_WINDOW   = 16'd100;
	localparam logic [CNT_CFG_BITS-1:0] RST_STOP_MAJORITY = 16'd50;

	typedef struct packed {
		logic add_en;    // add the lane's addend this beat
		logic clear;     // zero the sum (wins over add)
		logic load_div;  // block closes, prime the divider
		logic div_step;  // one quotient bit
		logic finish;    // latch the average, zero the sum
	} lane_ctl_t;

endpackage

[src/gated_multichannel_block_averager.sv]
// gated multichannel block averager
// s_* carries one sample set per beat (five adc channels), m_* one result per
// accepted set: the five held averages plus averages_ready and stop_seen flags.
// cfg_we/cfg_index/cfg_data write the six registers; write only while idle.
// mode 0 sums non-idle sets per channel and, after average_count sets,
// divides each sum by the tally; mode 1 counts idle samples of one channel
// over stop_window sets and flags an idle majority.
// a set that does not close a block goes from ST_IDLE through ST_OUT to the
// output register; a closing set goes through ST_DIV, ST_FIN and ST_OUT,
// held in ST_DIV by the bit-serial restoring divider in each of the five
// lanes, one quotient bit per cycle.
// one set is in work at a time; the next is taken as soon as the previous
// result sits in the output register, even while that result waits on
// m_tready. a stalled receiver holds the result and, once a second result is
// ready, holds s_tready low.
// reset clears sums, tally, held averages and restores register defaults.
module gated_multichannel_block_averager #(
	parameter int ADC_BITS   = 12,
	parameter int COUNT_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// fwd_sample, rvr_sample, vref_sample, magnitude_sample, phase_sample
	input  logic [((5*ADC_BITS+7)/8)*8-1:0]        s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// fwd_average, rvr_average, vref_average, magnitude_average, phase_average
	output logic [((5*ADC_BITS+7)/8)*8-1:0]        m_tdata,
	// averages_ready, stop_seen
	output logic [1:0]                             m_tuser,
	input  logic                                   cfg_we,
	input  logic [gmba_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [gmba_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
	import gmba_pkg::*;

	localparam int SUM_BITS   = ADC_BITS + COUNT_BITS;
	localparam int TDATA_BITS = ((NUM_CH*ADC_BITS+7)/8)*8;

	logic                    mode_q;
	logic                    stop_fwd_q;
	logic [THRESH_BITS-1:0]  threshold_q;
	logic [CNT_CFG_BITS-1:0] avg_count_q;
	logic [CNT_CFG_BITS-1:0] stop_window_q;
	logic [CNT_CFG_BITS-1:0] stop_major_q;

	logic                    m_tvalid_q;
	logic [TDATA_BITS-1:0]   m_tdata_q;
	logic [1:0]              m_tuser_q;

	lane_ctl_t               fwd_ctl, oth_ctl;
	lane_ctl_t               lane_ctl [NUM_CH];
	logic [ADC_BITS-1:0]     addend   [NUM_CH];
	logic [SUM_BITS-1:0]     sum_upd  [NUM_CH];
	logic [ADC_BITS-1:0]     average  [NUM_CH];
	logic [COUNT_BITS-1:0]   divisor;
	logic                    out_load, res_ready, res_stop, slot_free;
	logic [TDATA_BITS-1:0]   packed_avg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= RST_MODE;
			stop_fwd_q    <= RST_STOP_USES_FWD;
			threshold_q   <= RST_THRESHOLD;
			avg_count_q   <= RST_AVERAGE_COUNT;
			stop_window_q <= RST_STOP_WINDOW;
			stop_major_q  <= RST_STOP_MAJORITY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:          mode_q        <= cfg_data[0];
				REG_STOP_USES_FWD: stop_fwd_q    <= cfg_data[0];
				REG_THRESHOLD:     threshold_q   <= cfg_data[THRESH_BITS-1:0];
				REG_AVERAGE_COUNT: avg_count_q   <= cfg_data;
				REG_STOP_WINDOW:   stop_window_q <= cfg_data;
				REG_STOP_MAJORITY: stop_major_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// lane 0 doubles as the idle counter in stop mode
	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			lane_ctl[i] = (i == 0) ? fwd_ctl : oth_ctl;
			addend[i]   = s_tdata[i*ADC_BITS +: ADC_BITS];
		end
		if (mode_q) begin
			addend[0] = ADC_BITS'(1);
		end
	end

	for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
		gmba_lane #(
			.ADC_BITS   (ADC_BITS),
			.COUNT_BITS (COUNT_BITS)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (lane_ctl[g]),
			.addend  (addend[g]),
			.divisor (divisor),
			.sum_upd (sum_upd[g]),
			.average (average[g])
		);
	end

	gmba_ctrl #(
		.ADC_BITS   (ADC_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.fwd           (s_tdata[0 +: ADC_BITS]),
		.rvr           (s_tdata[ADC_BITS +: ADC_BITS]),
		.mode          (mode_q),
		.stop_uses_fwd (stop_fwd_q),
		.threshold     (threshold_q),
		.average_count (avg_count_q),
		.stop_window   (stop_window_q),
		.stop_majority (stop_major_q),
		.fwd_sum_upd   (sum_upd[0]),
		.slot_free     (slot_free),
		.fwd_ctl       (fwd_ctl),
		.oth_ctl       (oth_ctl),
		.divisor       (divisor),
		.out_load      (out_load),
		.res_ready     (res_ready),
		.res_stop      (res_stop)
	);

	// merge the lane averages into one result beat
	always_comb begin
		packed_avg = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			packed_avg[i*ADC_BITS +: ADC_BITS] = average[i];
		end
		slot_free = !m_tvalid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= packed_avg;
			m_tuser_q <= {res_stop, res_ready};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

[src/gmba_lane.sv]
module gmba_lane #(
	parameter int ADC_BITS   = 12,
	parameter int COUNT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gmba_pkg::lane_ctl_t            ctl,
	input  logic [ADC_BITS-1:0]            addend,
	input  logic [COUNT_BITS-1:0]          divisor,
	output logic [ADC_BITS+COUNT_BITS-1:0] sum_upd,
	output logic [ADC_BITS-1:0]            average
);
	import gmba_pkg::*;

	localparam int SUM_BITS = ADC_BITS + COUNT_BITS;

	logic [SUM_BITS-1:0]   sum_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [ADC_BITS-1:0]   avg_q;
	logic [SUM_BITS:0]     sum_wide;
	logic [SUM_BITS-1:0]   sum_next;
	logic [COUNT_BITS:0]   shifted;
	logic [COUNT_BITS:0]   diff;
	logic                  ge;

	always_comb begin
		sum_wide = {1'b0, sum_q} + (SUM_BITS+1)'(addend);
		sum_next = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];
		sum_upd  = ctl.add_en ? sum_next : sum_q;
		// restoring divide, the quotient shifts into the sum register
		shifted  = {rem_q, sum_q[SUM_BITS-1]};
		ge       = shifted >= {1'b0, divisor};
		diff     = shifted - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			avg_q <= '0;
		end else if (ctl.clear) begin
			sum_q <= '0;
		end else if (ctl.add_en) begin
			sum_q <= sum_next;
		end else if (ctl.div_step) begin
			sum_q <= {sum_q[SUM_BITS-2:0], ge};
		end else if (ctl.finish) begin
			avg_q <= (|sum_q[SUM_BITS-1:ADC_BITS]) ? {ADC_BITS{1'b1}} : sum_q[ADC_BITS-1:0];
			sum_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_div) begin
			rem_q <= '0;
		end else if (ctl.div_step) begin
			rem_q <= ge ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
		end
	end

	assign average = avg_q;

endmodule

[src/gmba_ctrl.sv]
`include "gated_multichannel_block_averager_defines.svh"

module gmba_ctrl #(
	parameter int ADC_BITS   = 12,
	parameter int COUNT_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [ADC_BITS-1:0]                  fwd,
	input  logic [ADC_BITS-1:0]                  rvr,
	input  logic                                 mode,
	input  logic                                 stop_uses_fwd,
	input  logic [gmba_pkg::THRESH_BITS-1:0]     threshold,
	input  logic [gmba_pkg::CNT_CFG_BITS-1:0]    average_count,
	input  logic [gmba_pkg::CNT_CFG_BITS-1:0]    stop_window,
	input  logic [gmba_pkg::CNT_CFG_BITS-1:0]    stop_majority,
	input  logic [ADC_BITS+COUNT_BITS-1:0]       fwd_sum_upd,
	input  logic                                 slot_free,
	output gmba_pkg::lane_ctl_t                  fwd_ctl,
	output gmba_pkg::lane_ctl_t                  oth_ctl,
	output logic [COUNT_BITS-1:0]                divisor,
	output logic                                 out_load,
	output logic                                 res_ready,
	output logic                                 res_stop
);
	import gmba_pkg::*;

	localparam int SUM_BITS     = ADC_BITS + COUNT_BITS;
	localparam int TH_BITS      = (ADC_BITS > THRESH_BITS) ? ADC_BITS : THRESH_BITS;
	localparam int CMP_BITS     = (COUNT_BITS > CNT_CFG_BITS) ? COUNT_BITS : CNT_CFG_BITS;
	localparam int DIV_CNT_BITS = $clog2(SUM_BITS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]              state_q;
	logic [COUNT_BITS-1:0]   tally_q;
	logic [COUNT_BITS-1:0]   divisor_q;
	logic [DIV_CNT_BITS-1:0] div_cnt_q;
	logic                    ready_q;
	logic                    stop_q;

	logic                    fire, f_idle, r_idle, watched_idle, counted, take;
	logic                    close, close_avg, close_stop, stop_gt;
	logic [COUNT_BITS-1:0]   tally_inc;
	logic [CNT_CFG_BITS-1:0] limit;

	always_comb begin
		s_tready     = (state_q == ST_IDLE);
		fire         = s_tvalid && s_tready;
		f_idle       = TH_BITS'(fwd) < TH_BITS'(threshold);
		r_idle       = TH_BITS'(rvr) < TH_BITS'(threshold);
		watched_idle = stop_uses_fwd ? f_idle : r_idle;
		counted      = mode || !(f_idle && r_idle);
		take         = fire && counted;
		// tally saturates, a full tally always closes
		tally_inc    = (&tally_q) ? tally_q : tally_q + 1'b1;
		limit        = mode ? stop_window : average_count;
		close        = (CMP_BITS'(tally_inc) >= CMP_BITS'(limit)) || (&tally_inc);
		close_avg    = take && !mode && close;
		close_stop   = take && mode && close;
		stop_gt      = fwd_sum_upd > SUM_BITS'(stop_majority);

		fwd_ctl.add_en   = take && (!mode || watched_idle);
		fwd_ctl.clear    = close_stop;
		fwd_ctl.load_div = close_avg;
		fwd_ctl.div_step = (state_q == ST_DIV);
		fwd_ctl.finish   = (state_q == ST_FIN);

		oth_ctl.add_en   = take && !mode;
		oth_ctl.clear    = 1'b0;
		oth_ctl.load_div = close_avg;
		oth_ctl.div_step = (state_q == ST_DIV);
		oth_ctl.finish   = (state_q == ST_FIN);

		out_load  = (state_q == ST_OUT) && slot_free;
		divisor   = divisor_q;
		res_ready = ready_q;
		res_stop  = stop_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			tally_q   <= '0;
			ready_q   <= 1'b0;
			stop_q    <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (fire) begin
						ready_q <= close_avg;
						stop_q  <= close_stop && stop_gt;
						if (take) begin
							tally_q <= close ? '0 : tally_inc;
						end
						if (close_avg) begin
							div_cnt_q <= DIV_CNT_BITS'(SUM_BITS - 1);
							state_q   <= ST_DIV;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (close_avg) begin
			divisor_q <= tally_inc;
		end
	end

	`GMBA_ASSERT(a_close_starts_div, close_avg |=> (state_q == ST_DIV), "block close did not start divide")
	`GMBA_ASSERT(a_close_clears_tally, (take && close) |=> (tally_q == '0), "tally not cleared at close")
	`GMBA_ASSERT(a_divisor_nonzero, (state_q == ST_DIV) |-> (divisor_q != '0), "zero divisor in divide")
	`GMBA_ASSERT(a_result_exclusive, out_load |-> !(ready_q && stop_q), "ready and stop in one result")
	`GMBA_ASSERT_ALWAYS(a_no_accept_busy, (fwd_ctl.div_step || fwd_ctl.finish) |-> !s_tready, "accept while dividing")

endmodule

[tb/sv/gated_multichannel_block_averager_test.sv]
`timescale 1ns / 1ps

module gated_multichannel_block_averager_test;
	import gmba_pkg::*;

	localparam int ADC_BITS   = 12;
	localparam int COUNT_BITS = 16;
	localparam int SUM_BITS   = ADC_BITS + COUNT_BITS;
	localparam logic [ADC_BITS-1:0] ADC_TOP = '1;

	// one sample set, or the five held averages, fwd in the lowest bits
	typedef struct packed {
		logic [ADC_BITS-1:0] phase;
		logic [ADC_BITS-1:0] magnitude;
		logic [ADC_BITS-1:0] vref;
		logic [ADC_BITS-1:0] rvr;
		logic [ADC_BITS-1:0] fwd;
	} sample_set_t;

	typedef struct packed {
		logic        stop_seen;
		logic        averages_ready;
		sample_set_t averages;
	} block_result_t;

	typedef enum logic {ROW_WRITE, ROW_SET} row_kind_t;

	typedef struct packed {
		row_kind_t                 kind;
		logic [CFG_INDEX_BITS-1:0] index;
		logic [CFG_DATA_BITS-1:0]  value;
		sample_set_t               samples;
		logic                      pinned;
		block_result_t             want;
	} dir_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	// fwd_sample, rvr_sample, vref_sample, magnitude_sample, phase_sample
	logic [63:0]               s_tdata = '0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b1;
	// fwd_average, rvr_average, vref_average, magnitude_average, phase_average
	logic [63:0]               m_tdata;
	// averages_ready, stop_seen
	logic [1:0]                m_tuser;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = REG_MODE;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	gated_multichannel_block_averager #(
		.ADC_BITS(ADC_BITS),
		.COUNT_BITS(COUNT_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor copy of the registers and the accumulation state
	logic                    cfg_mode = RST_MODE;
	logic                    cfg_watch_fwd = RST_STOP_USES_FWD;
	logic [THRESH_BITS-1:0]  cfg_threshold = RST_THRESHOLD;
	logic [CNT_CFG_BITS-1:0] cfg_block_len = RST_AVERAGE_COUNT;
	logic [CNT_CFG_BITS-1:0] cfg_window = RST_STOP_WINDOW;
	logic [CNT_CFG_BITS-1:0] cfg_majority = RST_STOP_MAJORITY;
	logic [SUM_BITS-1:0]     chan_sum [NUM_CH] = '{default: '0};
	logic [COUNT_BITS-1:0]   set_tally = '0;
	logic [ADC_BITS-1:0]     held_avg [NUM_CH] = '{default: '0};

	block_result_t awaited_outputs [$];
	dir_row_t      directed_rows [$];
	int            tx_idle_pct = 0;
	int            rx_stall_pct = 0;
	int            errors = 0;
	int            sets_sent = 0;
	int            results_checked = 0;
	int            blocks_closed = 0;
	int            stops_flagged = 0;

	task automatic advance_averager(input sample_set_t s, output block_result_t res);
		logic [ADC_BITS-1:0]   lvl [NUM_CH];
		logic [SUM_BITS:0]     wide;
		logic [SUM_BITS-1:0]   quot;
		logic [ADC_BITS-1:0]   watched;
		int                    c;
		lvl = '{s.fwd, s.rvr, s.vref, s.magnitude, s.phase};
		res = '0;
		if (cfg_mode == 1'b0) begin
			// a set is dropped only when both fwd and rvr sit below the threshold
			if (!(s.fwd < cfg_threshold && s.rvr < cfg_threshold)) begin
				for (c = 0; c < NUM_CH; c++) begin
					wide = chan_sum[c] + lvl[c];
					chan_sum[c] = wide[SUM_BITS] ? '1 : wide[SUM_BITS-1:0];
				end
				if (set_tally != '1)
					set_tally = set_tally + 1'b1;
				if (set_tally >= cfg_block_len || set_tally == '1) begin
					for (c = 0; c < NUM_CH; c++) begin
						quot = chan_sum[c] / set_tally;
						held_avg[c] = (quot > ADC_TOP) ? ADC_TOP : quot[ADC_BITS-1:0];
						chan_sum[c] = '0;
					end
					set_tally = '0;
					res.averages_ready = 1'b1;
				end
			end
		end else begin
			// stop mode reuses the fwd sum as the idle counter
			watched = cfg_watch_fwd ? s.fwd : s.rvr;
			if (watched < cfg_threshold && chan_sum[0] != '1)
				chan_sum[0] = chan_sum[0] + 1'b1;
			if (set_tally != '1)
				set_tally = set_tally + 1'b1;
			if (set_tally >= cfg_window || set_tally == '1) begin
				res.stop_seen = (chan_sum[0] > cfg_majority);
				chan_sum[0] = '0;
				set_tally = '0;
			end
		end
		res.averages = {held_avg[4], held_avg[3], held_avg[2], held_avg[1], held_avg[0]};
	endtask

	function automatic void field_check(string name, logic [ADC_BITS-1:0] want,
			logic [ADC_BITS-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		block_result_t got;
		block_result_t want;
		m_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser[1], m_tuser[0], m_tdata[59:0]};
			if (awaited_outputs.size() == 0) begin
				$error("result beat with no sample set outstanding");
				errors++;
			end else begin
				want = awaited_outputs.pop_front();
				field_check("fwd_average", want.averages.fwd, got.averages.fwd);
				field_check("rvr_average", want.averages.rvr, got.averages.rvr);
				field_check("vref_average", want.averages.vref, got.averages.vref);
				field_check("magnitude_average", want.averages.magnitude,
					got.averages.magnitude);
				field_check("phase_average", want.averages.phase, got.averages.phase);
				field_check("averages_ready", want.averages_ready, got.averages_ready);
				field_check("stop_seen", want.stop_seen, got.stop_seen);
				results_checked++;
				blocks_closed += got.averages_ready;
				stops_flagged += got.stop_seen;
			end
		end
	end

	task automatic send_set(input sample_set_t s, input logic pinned, input block_result_t want);
		block_result_t pred;
		cfg_we <= 1'b0;
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, s};
		do @(posedge clk); while (!s_tready);
		advance_averager(s, pred);
		awaited_outputs.push_back(pinned ? want : pred);
		sets_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (awaited_outputs.size() != 0)
			@(posedge clk);
	endtask

	// caller drains first so the block is idle
	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_MODE:          cfg_mode = val[0];
			REG_STOP_USES_FWD: cfg_watch_fwd = val[0];
			REG_THRESHOLD:     cfg_threshold = val[THRESH_BITS-1:0];
			REG_AVERAGE_COUNT: cfg_block_len = val;
			REG_STOP_WINDOW:   cfg_window = val;
			REG_STOP_MAJORITY: cfg_majority = val;
			default: ;
		endcase
	endtask

	// below and at the threshold, the rails, and random full-range levels
	function automatic logic [ADC_BITS-1:0] pick_level();
		case ($urandom_range(5))
			0: return (cfg_threshold == 0) ? '0 : ADC_BITS'($urandom_range(cfg_threshold - 1));
			1: return cfg_threshold;
			2: return '0;
			3: return ADC_TOP;
			default: return ADC_BITS'($urandom_range(ADC_TOP));
		endcase
	endfunction

	function automatic sample_set_t random_set();
		sample_set_t s;
		s.fwd = pick_level();
		s.rvr = pick_level();
		s.vref = pick_level();
		s.magnitude = pick_level();
		s.phase = pick_level();
		return s;
	endfunction

	task automatic run_phase(input int mode, input int watch_fwd,
			input int thr, input int blk, input int win, input int maj,
			input int tx_pct, input int rx_pct, input int n);
		drain_results();
		write_reg(REG_MODE, CFG_DATA_BITS'(mode));
		write_reg(REG_STOP_USES_FWD, CFG_DATA_BITS'(watch_fwd));
		write_reg(REG_THRESHOLD, CFG_DATA_BITS'(thr));
		write_reg(REG_AVERAGE_COUNT, CFG_DATA_BITS'(blk));
		write_reg(REG_STOP_WINDOW, CFG_DATA_BITS'(win));
		write_reg(REG_STOP_MAJORITY, CFG_DATA_BITS'(maj));
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		repeat (n) send_set(random_set(), 1'b0, '0);
	endtask

	function automatic dir_row_t wr_row(logic [CFG_INDEX_BITS-1:0] idx,
			logic [CFG_DATA_BITS-1:0] val);
		dir_row_t row;
		row = '0;
		row.kind = ROW_WRITE;
		row.index = idx;
		row.value = val;
		return row;
	endfunction

	function automatic dir_row_t set_row(logic [ADC_BITS-1:0] f, logic [ADC_BITS-1:0] r,
			logic [ADC_BITS-1:0] v, logic [ADC_BITS-1:0] m, logic [ADC_BITS-1:0] p);
		dir_row_t row;
		row = '0;
		row.kind = ROW_SET;
		row.samples = {p, m, v, r, f};
		return row;
	endfunction

	function automatic dir_row_t pin(dir_row_t row, logic rdy, logic stp, sample_set_t avg);
		row.pinned = 1'b1;
		row.want = {stp, rdy, avg};
		return row;
	endfunction

	initial begin
		int w;
		// reset defaults: averaging, threshold 10, long blocks
		directed_rows.push_back(pin(set_row(0, 0, 0, 0, 0), 0, 0, '0));
		directed_rows.push_back(pin(set_row(9, 9, 'hFFF, 'hFFF, 'hFFF), 0, 0, '0));
		directed_rows.push_back(pin(set_row(10, 0, 'h800, 'h800, 'h800), 0, 0, '0));
		directed_rows.push_back(wr_row(REG_AVERAGE_COUNT, 1));
		directed_rows.push_back(set_row('hFFF, 'hFFF, 'hFFF, 'hFFF, 'hFFF));
		directed_rows.push_back(pin(set_row('hFFF, 'hFFF, 'hFFF, 'hFFF, 'hFFF), 1, 0,
			{5{ADC_TOP}}));
		// zero count behaves as one
		directed_rows.push_back(wr_row(REG_AVERAGE_COUNT, 0));
		directed_rows.push_back(pin(set_row(0, 10, 'h555, 'hAAA, 'hFFF), 1, 0,
			{12'hFFF, 12'hAAA, 12'h555, 12'd10, 12'd0}));
		directed_rows.push_back(set_row(9, 0, 'h123, 'h456, 'h789));
		directed_rows.push_back(wr_row(REG_THRESHOLD, 0));
		directed_rows.push_back(pin(set_row(0, 0, 0, 0, 0), 1, 0, '0));
		directed_rows.push_back(wr_row(REG_THRESHOLD, 'hFFF));
		directed_rows.push_back(set_row('hFFE, 'hFFE, 'h123, 'h456, 'h789));
		directed_rows.push_back(set_row('hFFF, 'hFFE, 'hA5A, 'h5A5, 'h001));
		// stop detection, single-sample windows, then four-set and 65535-set windows
		directed_rows.push_back(wr_row(REG_MODE, 1));
		directed_rows.push_back(wr_row(REG_STOP_WINDOW, 0));
		directed_rows.push_back(wr_row(REG_STOP_MAJORITY, 0));
		directed_rows.push_back(set_row(0, 'hFFF, 'h3C3, 'hC3C, 'h0F0));
		directed_rows.push_back(set_row('hFFF, 0, 'h3C3, 'hC3C, 'h0F0));
		directed_rows.push_back(wr_row(REG_STOP_USES_FWD, 0));
		directed_rows.push_back(set_row('hFFF, 0, 'h111, 'h222, 'h333));
		directed_rows.push_back(wr_row(REG_STOP_WINDOW, 4));
		directed_rows.push_back(wr_row(REG_STOP_MAJORITY, 2));
		directed_rows.push_back(set_row('hFFF, 0, 1, 2, 3));
		directed_rows.push_back(set_row('hFFF, 5, 4, 5, 6));
		directed_rows.push_back(set_row(0, 'hFFF, 7, 8, 9));
		directed_rows.push_back(set_row('hFFF, 100, 10, 11, 12));
		directed_rows.push_back(wr_row(REG_STOP_WINDOW, 'hFFFF));
		directed_rows.push_back(wr_row(REG_STOP_MAJORITY, 'hFFFF));
		directed_rows.push_back(set_row(0, 0, 0, 0, 0));
		directed_rows.push_back(set_row('hFFF, 'hFFF, 'hFFF, 'hFFF, 'hFFF));
		// back to averaging with the stop tally and idle count carried over
		directed_rows.push_back(wr_row(REG_MODE, 0));
		directed_rows.push_back(wr_row(REG_AVERAGE_COUNT, 3));
		directed_rows.push_back(set_row('h800, 'h7FF, 'hABC, 'h0FF, 'hF00));
		directed_rows.push_back(set_row(1, 2, 'h555, 'hAAA, 'h5A5));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				drain_results();
				write_reg(directed_rows[i].index, directed_rows[i].value);
			end else begin
				send_set(directed_rows[i].samples, directed_rows[i].pinned,
					directed_rows[i].want);
			end
		end

		run_phase(0, 1, $urandom_range(200), $urandom_range(1, 8), $urandom_range(1, 65535),
			$urandom_range(65535), 0, 0, 185);
		w = $urandom_range(1, 12);
		run_phase(1, 1, $urandom_range(1, 4095), 10000, w, $urandom_range(w), 51, 0, 185);
		run_phase(0, $urandom_range(1), 4095, 0, 100, 50, 0, 51, 185);
		run_phase(1, 0, $urandom_range(1, 4095), 1, 0, 0, 15, 15, 185);
		// never closes: sums and tally run into the following stop phase
		run_phase(0, 1, 0, 65535, 100, 50, 0, 0, 185);
		w = $urandom_range(1, 20);
		run_phase(1, $urandom_range(1), $urandom_range(1, 4095), 7, w, 65535, 51, 0, 185);
		run_phase(0, 0, $urandom_range(4095), $urandom_range(2, 30), 1, 0, 0, 51, 185);
		run_phase(1, 1, $urandom_range(4095), 5, 65535, $urandom_range(65535), 15, 15, 185);

		drain_results();
		rx_stall_pct = 0;
		repeat (40) @(posedge clk);
		if (awaited_outputs.size() != 0) begin
			$error("%0d results never arrived", awaited_outputs.size());
			errors++;
		end
		$display("covered %0d sample sets over directed rows and 8 register settings,",
			sets_sent);
		$display("%0d results compared, %0d averaging blocks closed, %0d stop windows flagged",
			results_checked, blocks_closed, stops_flagged);
		if (errors == 0)
			$display("gated_multichannel_block_averager verification clean");
		else
			$display("gated_multichannel_block_averager verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("gated_multichannel_block_averager verification failed");
		$finish;
	end

endmodule
